// ===== rtl/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types, codes and helpers for the tag-only LRU cache simulator.
// ----------------------------------------------------------------------------
package sac_pkg;

	localparam int WAY_W  = 4;   // way index, covers up to 16 ways
	localparam int WCNT_W = 5;   // way count, holds 16 itself
	localparam int TAG_W  = 64;
	localparam int AGE_W  = 32;
	localparam int CNT_W  = 32;
	localparam int MAX_BLOCK_BITS = 32;

	typedef enum logic [1:0] {
		REG_SET_BITS   = 2'd0,
		REG_WAYS       = 2'd1,
		REG_BLOCK_BITS = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} line_t;

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] hit_way;
		logic             has_inv;
		logic [WAY_W-1:0] inv_way;
		logic [WAY_W-1:0] victim_way;
	} eval_res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ===== rtl/set_assoc_cache_lru_sim_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top
// Tag-only set-associative cache simulator with LRU replacement.
// ----------------------------------------------------------------------------
// After reset the block sweeps its line store once, one line per cycle,
// clearing 2^MAX_SET_BITS * MAX_WAYS lines (512 with the defaults), and
// takes no trace item until that sweep is done; configuration writes are
// taken at any time. Each access reads the ways of its set one per cycle
// through the single read port of the line store and one shared tag/age
// evaluator, then writes the chosen line back; a modify scans and writes
// its set twice. The block holds one item at a time; a finished result
// sits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_top import sac_pkg::*; #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [63:0] address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  outcome,
	output logic        second_hit,
	output logic [31:0] hit_count,
	output logic [31:0] miss_count,
	output logic [31:0] eviction_count
);

	localparam int LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
	localparam int AW    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int LINE_W = $bits(line_t);

	// configuration
	logic [2:0] set_bits_q;
	logic [3:0] ways_q;
	logic [5:0] block_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 3'd0;
			ways_q       <= 4'd1;
			block_bits_q <= 6'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
				REG_WAYS:       ways_q       <= cfg_data[3:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [3:0]        sb;
	logic [5:0]        bb;
	logic [6:0]        shamt;
	logic [WCNT_W-1:0] nw;
	logic [63:0]       set_full;
	logic [SET_W-1:0]  set_idx;
	logic [TAG_W-1:0]  tag_in;
	logic [AW-1:0]     base_in;

	always_comb begin
		sb = (32'(set_bits_q) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : 4'(set_bits_q);
		bb = (block_bits_q > 6'(MAX_BLOCK_BITS)) ? 6'(MAX_BLOCK_BITS) : block_bits_q;
		if (ways_q == 4'd0) begin
			nw = WCNT_W'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			nw = WCNT_W'(MAX_WAYS);
		end else begin
			nw = WCNT_W'(ways_q);
		end
		shamt    = 7'(sb) + 7'(bb);
		set_full = (address >> bb) & ((64'd1 << sb) - 64'd1);
		set_idx  = set_full[SET_W-1:0];
		tag_in   = address >> shamt;
		base_in  = AW'(32'(set_idx) * MAX_WAYS);
	end

	// sequencer state
	state_t            state_q, state_d;
	logic [AW-1:0]     clr_idx_q;
	logic [WCNT_W-1:0] rd_way_q;
	logic              ev_s1;
	logic [WAY_W-1:0]  ev_way_s1;
	logic [AW-1:0]     base_q;
	logic [TAG_W-1:0]  tag_q;
	logic              modify_q;
	logic              second_q;
	outcome_t          first_q;
	logic              sec_hit_q;
	logic [AGE_W-1:0]  age_clock_q;
	logic [CNT_W-1:0]  hits_q, misses_q, evicts_q;

	// output register
	logic              out_valid_q;
	outcome_t          out_outcome_q;
	logic              out_sec_q;
	logic [CNT_W-1:0]  out_hits_q, out_misses_q, out_evicts_q;

	// datapath wiring
	eval_res_t         res;
	line_t             rd_line;
	logic [LINE_W-1:0] rdata;
	line_t             wr_line;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic              ram_we;
	logic              issue;
	logic              do_write;
	logic              load_out;
	logic              eval_clr;
	logic              accept;
	logic [WAY_W-1:0]  sel_way;
	outcome_t          outcome_cur;

	always_comb begin
		if (res.hit) begin
			sel_way     = res.hit_way;
			outcome_cur = OUT_HIT;
		end else if (res.has_inv) begin
			sel_way     = res.inv_way;
			outcome_cur = OUT_FILL;
		end else begin
			sel_way     = res.victim_way;
			outcome_cur = OUT_EVICT;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = clr_idx_q;
		wr_line   = '0;
		issue     = 1'b0;
		do_write  = 1'b0;
		load_out  = 1'b0;
		eval_clr  = 1'b0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_idx_q == AW'(LINES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				eval_clr = 1'b1;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = (rd_way_q < nw);
				// last way evaluated this cycle
				if (ev_s1 && (WCNT_W'(ev_way_s1) == nw - WCNT_W'(1))) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				do_write      = 1'b1;
				ram_we        = 1'b1;
				ram_waddr     = base_q + AW'(sel_way);
				wr_line.valid = 1'b1;
				wr_line.tag   = tag_q;
				wr_line.age   = age_clock_q;
				eval_clr      = 1'b1;
				state_d       = (modify_q && !second_q) ? ST_SCAN : ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept    = in_valid && in_ready;
	assign ram_raddr = base_q + AW'(rd_way_q);
	assign rd_line   = line_t'(rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			rd_way_q    <= '0;
			ev_s1       <= 1'b0;
			ev_way_s1   <= '0;
			second_q    <= 1'b0;
			first_q     <= OUT_HIT;
			sec_hit_q   <= 1'b0;
			age_clock_q <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			ev_s1 <= issue;
			if (issue) begin
				rd_way_q  <= rd_way_q + WCNT_W'(1);
				ev_way_s1 <= rd_way_q[WAY_W-1:0];
			end
			if (accept) begin
				rd_way_q  <= '0;
				second_q  <= 1'b0;
				sec_hit_q <= 1'b0;
			end
			if (do_write) begin
				rd_way_q    <= '0;
				age_clock_q <= age_clock_q + AGE_W'(1);
				if (res.hit) begin
					hits_q <= sat_inc(hits_q);
				end else begin
					misses_q <= sat_inc(misses_q);
					if (!res.has_inv) begin
						evicts_q <= sat_inc(evicts_q);
					end
				end
				if (!second_q) begin
					first_q  <= outcome_cur;
					second_q <= 1'b1;
				end else begin
					sec_hit_q <= res.hit;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q   <= base_in;
			tag_q    <= tag_in;
			modify_q <= req_type;
		end
		if (load_out) begin
			out_outcome_q <= first_q;
			out_sec_q     <= sec_hit_q;
			out_hits_q    <= hits_q;
			out_misses_q  <= misses_q;
			out_evicts_q  <= evicts_q;
		end
	end

	sac_ram #(
		.WIDTH (LINE_W),
		.DEPTH (LINES),
		.AW    (AW)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_line),
		.re    (issue),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	sac_way_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (eval_clr),
		.ev        (ev_s1),
		.way       (ev_way_s1),
		.line      (rd_line),
		.ref_tag   (tag_q),
		.age_clock (age_clock_q),
		.res       (res)
	);

	assign out_valid      = out_valid_q;
	assign outcome        = out_outcome_q;
	assign second_hit     = out_sec_q;
	assign hit_count      = out_hits_q;
	assign miss_count     = out_misses_q;
	assign eviction_count = out_evicts_q;

endmodule

// ===== rtl/sac_ram.sv =====
// ----------------------------------------------------------------------------
// sac_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sac_ram #(
	parameter int WIDTH = 97,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sac_way_eval.sv =====
// ----------------------------------------------------------------------------
// sac_way_eval
// Shared way evaluator: takes one way of a set per cycle, compares its tag,
// tracks the first hit, the first invalid way and the oldest line.
// ----------------------------------------------------------------------------
module sac_way_eval import sac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             ev,
	input  logic [WAY_W-1:0] way,
	input  line_t            line,
	input  logic [TAG_W-1:0] ref_tag,
	input  logic [AGE_W-1:0] age_clock,
	output eval_res_t        res
);

	logic             hit_q;
	logic [WAY_W-1:0] hit_way_q;
	logic             has_inv_q;
	logic [WAY_W-1:0] inv_way_q;
	logic [WAY_W-1:0] victim_q;
	logic [AGE_W-1:0] oldest_q;

	logic [AGE_W-1:0] age;
	logic             match;
	logic             older;

	always_comb begin
		// age wraps modulo 2^32, so plain subtraction is right
		age   = age_clock - line.age;
		match = line.valid && (line.tag == ref_tag);
		older = (way == '0) || (age > oldest_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			hit_way_q <= '0;
			has_inv_q <= 1'b0;
			inv_way_q <= '0;
			victim_q  <= '0;
			oldest_q  <= '0;
		end else if (clr) begin
			hit_q     <= 1'b0;
			has_inv_q <= 1'b0;
		end else if (ev) begin
			if (match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_way_q <= way;
			end
			if (!line.valid && !has_inv_q) begin
				has_inv_q <= 1'b1;
				inv_way_q <= way;
			end
			// strict compare keeps the lowest way on a tie
			if (older) begin
				oldest_q <= age;
				victim_q <= way;
			end
		end
	end

	always_comb begin
		res.hit        = hit_q;
		res.hit_way    = hit_way_q;
		res.has_inv    = has_inv_q;
		res.inv_way    = inv_way_q;
		res.victim_way = victim_q;
	end

endmodule
